### design/ter_pkg.sv
`default_nettype none

package ter_pkg;

   // Envelope and coefficient formats
   localparam int ENV_W    = 24;             // unsigned Q1.23
   localparam int COEF_W   = 16;             // Q0.16 pole
   localparam int MUL_A_W  = COEF_W + 1;     // pole or its complement (up to 1.0)
   localparam int ACC_W    = MUL_A_W + ENV_W; // product / accumulator width
   localparam int DEN_W    = ENV_W + 1;      // sustain + 1 LSB
   localparam int RATIO_W  = 17;             // unsigned Q1.16
   localparam int QUO_BITS = 16;             // quotient bits below saturation
   localparam int CNT_W    = 4;              // iteration counter for QUO_BITS

   localparam logic [MUL_A_W-1:0] COEF_ONE      = 17'd65536;
   localparam logic [MUL_A_W-1:0] SUSTAIN_POLE  = 17'd65470;  // 0.999
   localparam logic [MUL_A_W-1:0] SUSTAIN_GAIN  = 17'd66;     // 1 - 0.999
   localparam logic [ACC_W-1:0]   ROUND_HALF    = 41'd32768;
   localparam logic [RATIO_W-1:0] RATIO_ONE     = 17'd65536;

   // Register file
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;
   localparam int CHAN_W      = 2;

   localparam logic [CSR_INDEX_W-1:0] CSR_CHANNEL_COUNT = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ATTACK_COEFF  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_RELEASE_COEFF = 2'd2;

   localparam logic [CHAN_W-1:0] CHANNEL_COUNT_RESET = 2'd2;
   localparam logic [COEF_W-1:0] ATTACK_RESET        = 16'd65082;
   localparam logic [COEF_W-1:0] RELEASE_RESET       = 16'd65509;

   // Sequencer to divider
   typedef struct packed {
      logic             start;
      logic [ENV_W-1:0] dividend;
      logic [DEN_W-1:0] divisor;
   } div_ctl_type;

   typedef struct packed {
      logic               done;
      logic [RATIO_W-1:0] quotient;
   } div_status_type;

endpackage

`default_nettype wire

### design/ter_divider.sv
`default_nettype none

// Restoring divider: (dividend << 16) / divisor, saturated to 1.0 in Q1.16.
module ter_divider (
   input  wire                      clock,
   input  wire                      reset,
   input  wire ter_pkg::div_ctl_type ctl,
   output ter_pkg::div_status_type  status
);
   import ter_pkg::*;

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [DEN_W-1:0]   rem_ff, rem_in;
   logic [DEN_W-1:0]   den_ff, den_in;
   logic [RATIO_W-1:0] quo_ff, quo_in;

   logic [DEN_W:0]     shifted;
   logic               qbit;

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      quo_in   = quo_ff;
      shifted  = {rem_ff, 1'b0};
      qbit     = (shifted >= {1'b0, den_ff});

      if (ctl.start) begin
         den_in = ctl.divisor;
         if ({1'b0, ctl.dividend} >= ctl.divisor) begin
            // quotient would reach 1.0 or more
            quo_in  = RATIO_ONE;
            done_in = 1'b1;
         end else begin
            rem_in   = {1'b0, ctl.dividend};
            quo_in   = '0;
            count_in = CNT_W'(QUO_BITS - 1);
            busy_in  = 1'b1;
         end
      end else if (busy_ff) begin
         if (qbit) begin
            rem_in = DEN_W'(shifted - {1'b0, den_ff});
         end else begin
            rem_in = shifted[DEN_W-1:0];
         end
         quo_in   = {quo_ff[RATIO_W-2:0], qbit};
         count_in = count_ff - 1'b1;
         if (count_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      count_ff <= count_in;
      rem_ff   <= rem_in;
      den_ff   <= den_in;
      quo_ff   <= quo_in;
   end

   assign status.done     = done_ff;
   assign status.quotient = quo_ff;

endmodule

`default_nettype wire

### design/transient_envelope_ratio.sv
`default_nettype none

// Attack/release envelope follower that rates how transient an audio block is.
// Each req word is one frame: one or two signed samples (SAMPLE_BITS wide,
// full scale 1.0). The frame level is the mean channel magnitude in Q1.23.
// A peak envelope tracks it with the attack pole when the level is above the
// envelope and the release pole otherwise; a sustain envelope tracks it with
// a fixed 0.999 pole. Updates are env' = c*env + (1-c)*x, rounded half up.
// On a frame with req_last set, the block emits one rsp word:
// peak / (sustain + 1 LSB) in Q1.16, saturated at 1.0, then zeroes both
// envelopes. Other frames give no rsp word.
// Datapath: one shared 17x24 multiplier does the four products of a frame,
// one per cycle, behind a product register, so a frame holds req_stall high
// through its multiply steps. A last frame then keeps it high while the
// bit-serial divider finds 16 quotient bits, or gives 1.0 without iterating
// when the ratio saturates. The rsp word sits in an output register; the next
// frame is taken while it waits for the consumer, and a later last frame holds
// in S_OUT until it is taken. Configuration (channel_count, attack_coeff,
// release_coeff) must be written by the user only while the block is idle;
// the block does not enforce it. channel_count 0 acts as 1 and 3 acts as 2.
module transient_envelope_ratio #(
   parameter int SAMPLE_BITS  = 16,
   parameter int MAX_CHANNELS = 2
) (
   input  wire                               clock,
   input  wire                               reset,
   // frame input
   input  wire                               req_valid,
   output logic                              req_stall,
   input  wire  [SAMPLE_BITS-1:0]            req_left_sample,
   input  wire  [SAMPLE_BITS-1:0]            req_right_sample,
   input  wire                               req_last,
   // ratio output
   output logic                              rsp_valid,
   input  wire                               rsp_stall,
   output logic [ter_pkg::RATIO_W-1:0]       rsp_intensity,
   // register writes
   input  wire                               csr_write_enable,
   input  wire  [ter_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire  [ter_pkg::CSR_DATA_W-1:0]    csr_data
);
   import ter_pkg::*;

   // sequencer
   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_MAC     = 3'd1;
   localparam logic [2:0] S_DIV_GO  = 3'd2;
   localparam logic [2:0] S_DIV_RUN = 3'd3;
   localparam logic [2:0] S_OUT     = 3'd4;

   // multiply-accumulate steps within S_MAC
   localparam logic [2:0] STEP_PEAK_ENV  = 3'd0;  // pole * peak
   localparam logic [2:0] STEP_PEAK_IN   = 3'd1;  // (1-pole) * level
   localparam logic [2:0] STEP_SUST_ENV  = 3'd2;  // 0.999 * sustain, peak done
   localparam logic [2:0] STEP_SUST_IN   = 3'd3;  // 0.001 * level
   localparam logic [2:0] STEP_SUST_DONE = 3'd4;  // sustain done

   localparam int MAG_SHIFT = ENV_W - SAMPLE_BITS;

   logic [2:0]          state_ff, state_in;
   logic [2:0]          step_ff, step_in;
   logic [CHAN_W-1:0]   channel_count_ff, channel_count_in;
   logic [COEF_W-1:0]   attack_ff, attack_in;
   logic [COEF_W-1:0]   release_ff, release_in;
   logic [ENV_W-1:0]    level_ff, level_in;
   logic                last_ff, last_in;
   logic [COEF_W-1:0]   coef_ff, coef_in;
   logic [ENV_W-1:0]    peak_ff, peak_in;
   logic [ENV_W-1:0]    sustain_ff, sustain_in;
   logic [ACC_W-1:0]    prod_ff, prod_in;
   logic [ACC_W-1:0]    acc_ff, acc_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [RATIO_W-1:0]  rsp_intensity_ff, rsp_intensity_in;

   logic [SAMPLE_BITS-1:0] left_mag, right_mag;
   logic [ENV_W-1:0]       left_q23, right_q23;
   logic [ENV_W:0]         chan_sum;
   logic                   two_channels;
   logic [ENV_W-1:0]       frame_level;
   logic                   req_accept;
   logic                   out_free;

   logic [MUL_A_W-1:0]  mul_a;
   logic [ENV_W-1:0]    mul_b;
   logic [ACC_W-1:0]    acc_sum;

   div_ctl_type         div_ctl;
   div_status_type      div_status;

   // ---- frame level ----
   always_comb begin
      // two's complement negate; the most negative code reads as exactly 1.0
      left_mag  = req_left_sample[SAMPLE_BITS-1]  ? (~req_left_sample + 1'b1)
                                                  : req_left_sample;
      right_mag = req_right_sample[SAMPLE_BITS-1] ? (~req_right_sample + 1'b1)
                                                  : req_right_sample;
      left_q23  = ENV_W'(left_mag)  << MAG_SHIFT;
      right_q23 = ENV_W'(right_mag) << MAG_SHIFT;
      chan_sum  = {1'b0, left_q23} + {1'b0, right_q23};
      // counts 2 and 3 mean two channels, 0 and 1 mean one
      two_channels = channel_count_ff[1] && (MAX_CHANNELS >= 2);
      frame_level  = two_channels ? chan_sum[ENV_W:1] : left_q23;
   end

   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   // ---- shared multiplier operands ----
   always_comb begin
      case (step_ff)
         STEP_PEAK_ENV: begin
            mul_a = {1'b0, coef_ff};
            mul_b = peak_ff;
         end
         STEP_PEAK_IN: begin
            mul_a = COEF_ONE - {1'b0, coef_ff};
            mul_b = level_ff;
         end
         STEP_SUST_ENV: begin
            mul_a = SUSTAIN_POLE;
            mul_b = sustain_ff;
         end
         STEP_SUST_IN: begin
            mul_a = SUSTAIN_GAIN;
            mul_b = level_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_in = ACC_W'(mul_a) * ACC_W'(mul_b);
   assign acc_sum = acc_ff + prod_ff;

   // ---- sequencer ----
   always_comb begin
      state_in         = state_ff;
      step_in          = step_ff;
      channel_count_in = channel_count_ff;
      attack_in        = attack_ff;
      release_in       = release_ff;
      level_in         = level_ff;
      last_in          = last_ff;
      coef_in          = coef_ff;
      peak_in          = peak_ff;
      sustain_in       = sustain_ff;
      acc_in           = acc_ff;
      rsp_valid_in     = rsp_valid_ff && rsp_stall;
      rsp_intensity_in = rsp_intensity_ff;
      div_ctl.start    = 1'b0;
      div_ctl.dividend = peak_ff;
      div_ctl.divisor  = {1'b0, sustain_ff} + 1'b1;

      if (csr_write_enable) begin
         case (csr_index)
            CSR_CHANNEL_COUNT: channel_count_in = csr_data[CHAN_W-1:0];
            CSR_ATTACK_COEFF:  attack_in        = csr_data[COEF_W-1:0];
            CSR_RELEASE_COEFF: release_in       = csr_data[COEF_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               level_in = frame_level;
               last_in  = req_last;
               // equal level takes the release pole
               coef_in  = (frame_level > peak_ff) ? attack_ff : release_ff;
               step_in  = STEP_PEAK_ENV;
               state_in = S_MAC;
            end
         end
         S_MAC: begin
            // product register runs one step behind the operand select
            step_in = step_ff + 1'b1;
            if (step_ff inside {STEP_PEAK_ENV, STEP_SUST_ENV}) begin
               acc_in = ROUND_HALF;
            end else begin
               acc_in = acc_sum;
            end
            if (step_ff == STEP_SUST_ENV) begin
               peak_in = acc_sum[COEF_W +: ENV_W];
            end
            if (step_ff == STEP_SUST_DONE) begin
               sustain_in = acc_sum[COEF_W +: ENV_W];
               state_in   = last_ff ? S_DIV_GO : S_IDLE;
            end
         end
         S_DIV_GO: begin
            div_ctl.start = 1'b1;
            state_in      = S_DIV_RUN;
         end
         S_DIV_RUN: begin
            if (div_status.done) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (out_free) begin
               rsp_valid_in     = 1'b1;
               rsp_intensity_in = div_status.quotient;
               peak_in          = '0;
               sustain_in       = '0;
               state_in         = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_IDLE;
         step_ff          <= STEP_PEAK_ENV;
         channel_count_ff <= CHANNEL_COUNT_RESET;
         attack_ff        <= ATTACK_RESET;
         release_ff       <= RELEASE_RESET;
         peak_ff          <= '0;
         sustain_ff       <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         step_ff          <= step_in;
         channel_count_ff <= channel_count_in;
         attack_ff        <= attack_in;
         release_ff       <= release_in;
         peak_ff          <= peak_in;
         sustain_ff       <= sustain_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
      level_ff         <= level_in;
      last_ff          <= last_in;
      coef_ff          <= coef_in;
      prod_ff          <= prod_in;
      acc_ff           <= acc_in;
      rsp_intensity_ff <= rsp_intensity_in;
   end

   ter_divider u_divider (
      .clock  (clock),
      .reset  (reset),
      .ctl    (div_ctl),
      .status (div_status)
   );

   assign req_stall     = (state_ff != S_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_intensity = rsp_intensity_ff;

endmodule

`default_nettype wire

### design/ter_monitor.sv
`default_nettype none

module ter_monitor (
   input wire                         clock,
   input wire                         reset,
   input wire                         req_valid,
   input wire                         req_stall,
   input wire                         rsp_valid,
   input wire                         rsp_stall,
   input wire [ter_pkg::RATIO_W-1:0]  rsp_intensity
);
   import ter_pkg::*;

   // a waiting word holds until taken
   rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_intensity))
      else $error("rsp word changed while stalled");

   // ratio never exceeds 1.0
   ratio_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_intensity <= RATIO_ONE)
      else $error("rsp_intensity above 1.0");

   // a frame keeps the input side busy through its five multiply steps
   frame_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall ##1 req_stall ##1 req_stall
                                  ##1 req_stall ##1 req_stall)
      else $error("frame accepted during envelope update");

   // reset empties the output register
   reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp word present after reset");

endmodule

bind transient_envelope_ratio ter_monitor u_ter_monitor (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_intensity (rsp_intensity)
);

`default_nettype wire
